// ===== rtl/lom_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lom_pkg: shared types and constants of the limit order matcher
// Field widths, mode and result codes, book cell entry and book command types.
// ----------------------------------------------------------------------------
package lom_pkg;

   localparam int ID_W     = 10;
   localparam int SIZE_W   = 16;
   localparam int PRICE_W  = 10;
   localparam int SUM_W    = 22;

   localparam int MAX_MESSAGES = 1024;
   localparam int PRICE_LEVELS = 1024;
   localparam logic [PRICE_W-1:0] PRICE_TOP = PRICE_W'(PRICE_LEVELS - 1);
   localparam logic [ID_W-1:0]    ID_LAST   = ID_W'(MAX_MESSAGES - 1);

   // adder tree over the book cells
   localparam int TREE_LEAVES = 64;
   localparam int TREE_LEVELS = 6;
   localparam int WAIT_W      = $clog2(TREE_LEVELS + 1);

   // input modes
   localparam logic [1:0] MODE_BUY    = 2'd0;
   localparam logic [1:0] MODE_SELL   = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   // result kinds
   localparam logic KIND_TRADE = 1'b0;
   localparam logic KIND_QUOTE = 1'b1;

   typedef enum logic [2:0] {
      BOOK_HOLD,
      BOOK_REMOVE,
      BOOK_INSERT,
      BOOK_FILL,
      BOOK_POP
   } book_op_type;

   typedef struct packed {
      logic               valid;
      logic [ID_W-1:0]    id;
      logic [PRICE_W-1:0] limit;
      logic [SIZE_W-1:0]  rem;
   } entry_type;

   typedef struct packed {
      book_op_type       op;
      logic [ID_W-1:0]   id;
      entry_type         ent;
      logic [SIZE_W-1:0] fill;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WITHDRAW,
      ST_MATCH,
      ST_REST,
      ST_CXL_READ,
      ST_CXL_CHECK,
      ST_QUOTE
   } state_type;

   typedef struct packed {
      logic               kind;
      logic [SIZE_W-1:0]  trade_size;
      logic [PRICE_W-1:0] trade_price;
      logic [SUM_W-1:0]   bid_total;
      logic [PRICE_W-1:0] bid_level;
      logic [SUM_W-1:0]   ask_total;
      logic [PRICE_W-1:0] ask_level;
      logic               overflow;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/lom_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lom_req_if: order message channel
// Valid/ready channel carrying one order or cancel message per beat.
// ----------------------------------------------------------------------------
interface lom_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  mode;
   logic [lom_pkg::SIZE_W-1:0]  order_size;
   logic [lom_pkg::PRICE_W-1:0] price;
   logic [lom_pkg::ID_W-1:0]    target_order;

   modport source (output valid, mode, order_size, price, target_order, input ready);
   modport sink   (input valid, mode, order_size, price, target_order, output ready);
endinterface
`default_nettype wire

// ===== rtl/lom_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lom_rsp_if: trade and quote result channel
// Valid/ready channel carrying one trade or quote report per beat.
// ----------------------------------------------------------------------------
interface lom_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [lom_pkg::SIZE_W-1:0]  trade_size;
   logic [lom_pkg::PRICE_W-1:0] trade_price;
   logic [lom_pkg::SUM_W-1:0]   bid_total;
   logic [lom_pkg::PRICE_W-1:0] bid_level;
   logic [lom_pkg::SUM_W-1:0]   ask_total;
   logic [lom_pkg::PRICE_W-1:0] ask_level;
   logic                        overflow;
   logic                        last;

   modport source (output valid, kind, trade_size, trade_price, bid_total, bid_level,
                   ask_total, ask_level, overflow, last, input ready);
   modport sink   (input valid, kind, trade_size, trade_price, bid_total, bid_level,
                   ask_total, ask_level, overflow, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/lom_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lom_cell: one slot of a sorted order book
// Holds one resting order and shifts toward or away from the head together
// with its neighbors on remove, insert and pop.
// ----------------------------------------------------------------------------
module lom_cell #(
   parameter bit IS_BID = 1'b1
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire lom_pkg::cmd_type   cmd,
   input  wire                     head,
   input  wire lom_pkg::entry_type prev_ent,
   input  wire lom_pkg::entry_type next_ent,
   input  wire                     prev_better,
   input  wire                     pass_in,
   output lom_pkg::entry_type      ent,
   output logic                    better,
   output logic                    pass_out
);

   lom_pkg::entry_type ent_ff, ent_in;
   logic               hit;

   // match on id for removal; priority compare for insertion
   assign hit      = ent_ff.valid && (ent_ff.id == cmd.id);
   assign pass_out = pass_in || hit;
   assign better   = ent_ff.valid &&
                     (IS_BID ? (ent_ff.limit >= cmd.ent.limit)
                             : (ent_ff.limit <= cmd.ent.limit));
   assign ent      = ent_ff;

   // next slot contents
   always_comb begin
      ent_in = ent_ff;
      unique case (cmd.op)
         lom_pkg::BOOK_REMOVE: begin
            if (pass_in || hit) ent_in = next_ent;
         end
         lom_pkg::BOOK_INSERT: begin
            if (!better) ent_in = prev_better ? cmd.ent : prev_ent;
         end
         lom_pkg::BOOK_FILL: begin
            if (head) ent_in.rem = ent_ff.rem - cmd.fill;
         end
         lom_pkg::BOOK_POP: begin
            ent_in = next_ent;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
      end else begin
         ent_ff <= ent_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/lom_sum_tree.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lom_sum_tree: registered adder tree
// Sums the leaf quantities with one register level per tree level; the total
// is taken from the registered root node.
// ----------------------------------------------------------------------------
module lom_sum_tree (
   input  wire                        clock,
   input  wire [lom_pkg::SIZE_W-1:0]  leaf [lom_pkg::TREE_LEAVES],
   output logic [lom_pkg::SUM_W-1:0]  total
);

   localparam int NODES = lom_pkg::TREE_LEAVES - 1;

   // heap order: node i has children 2i+1 and 2i+2, leaves follow the nodes
   logic [lom_pkg::SUM_W-1:0] node_ff [NODES];

   for (genvar i = 0; i < NODES; i++) begin : g_node
      logic [lom_pkg::SUM_W-1:0] lft, rgt;
      if (2 * i + 1 >= NODES) begin : g_leaf
         assign lft = lom_pkg::SUM_W'(leaf[2 * i + 1 - NODES]);
         assign rgt = lom_pkg::SUM_W'(leaf[2 * i + 2 - NODES]);
      end else begin : g_inner
         assign lft = node_ff[2 * i + 1];
         assign rgt = node_ff[2 * i + 2];
      end
      always_ff @(posedge clock) begin
         node_ff[i] <= lft + rgt;
      end
   end

   assign total = node_ff[0];

endmodule
`default_nettype wire

// ===== rtl/lom_book.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lom_book: one side of the order book
// Chain of cells sorted by price then arrival, plus the adder tree that totals
// the resting size at the head price.
// ----------------------------------------------------------------------------
module lom_book #(
   parameter int DEPTH  = 63,
   parameter bit IS_BID = 1'b1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire lom_pkg::cmd_type      cmd,
   output lom_pkg::entry_type         head_ent,
   output logic                       full,
   output logic [lom_pkg::SUM_W-1:0]  head_total
);

   lom_pkg::entry_type        ent    [DEPTH];
   logic                      better [DEPTH];
   logic                      pass   [DEPTH];
   logic [lom_pkg::SIZE_W-1:0] leaf  [lom_pkg::TREE_LEAVES];

   // cell chain
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      lom_pkg::entry_type prev_e, next_e;
      logic               prev_b, pass_i;
      if (k == 0) begin : g_first
         assign prev_e = '0;
         assign prev_b = 1'b1;
         assign pass_i = 1'b0;
      end else begin : g_mid
         assign prev_e = ent[k-1];
         assign prev_b = better[k-1];
         assign pass_i = pass[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_nlast
         assign next_e = ent[k+1];
      end
      lom_cell #(.IS_BID(IS_BID)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .head        (k == 0),
         .prev_ent    (prev_e),
         .next_ent    (next_e),
         .prev_better (prev_b),
         .pass_in     (pass_i),
         .ent         (ent[k]),
         .better      (better[k]),
         .pass_out    (pass[k])
      );
   end

   // resting size of every cell at the head price
   for (genvar k = 0; k < lom_pkg::TREE_LEAVES; k++) begin : g_leaf
      if (k < DEPTH) begin : g_used
         assign leaf[k] = (ent[k].valid && (ent[k].limit == ent[0].limit))
                          ? ent[k].rem : '0;
      end else begin : g_pad
         assign leaf[k] = '0;
      end
   end

   lom_sum_tree u_tree (
      .clock (clock),
      .leaf  (leaf),
      .total (head_total)
   );

   assign head_ent = ent[0];
   assign full     = ent[DEPTH-1].valid;

endmodule
`default_nettype wire

// ===== rtl/limit_order_matcher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_matcher_unit: price-time priority limit order book
// Matches buy and sell orders, handles cancels, reports trades and quotes.
// ----------------------------------------------------------------------------
// One message is handled at a time. After reset a clearing pass empties the
// cancel flags before the first message is taken. A buy or sell withdraws any
// order under its number, trades against the opposite head one trade at a
// time, then rests any remainder if its side has room; a cancel reads and
// checks its flag. Any step that sends a result waits while the result side
// stalls. Each message ends by waiting on the six-level registered adder tree
// that totals the resting size at the best price for the quote; the withdraw,
// match and insert steps move every book cell in step with its neighbors.
// ----------------------------------------------------------------------------
module limit_order_matcher_unit #(
   parameter int BOOK_DEPTH = 63
) (
   input  wire          clock,
   input  wire          reset,
   lom_req_if.sink      req_chan,
   lom_rsp_if.source    rsp_chan
);

   lom_pkg::state_type state_ff, state_in;

   logic [lom_pkg::ID_W-1:0]    cnt_ff, cnt_in;
   logic [lom_pkg::ID_W-1:0]    clr_ff, clr_in;
   logic [1:0]                  mode_ff, mode_in;
   logic [lom_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic [lom_pkg::PRICE_W-1:0] limit_ff, limit_in;
   logic [lom_pkg::ID_W-1:0]    target_ff, target_in;
   logic [lom_pkg::ID_W-1:0]    id_ff, id_in;
   logic                        ovf_ff, ovf_in;
   logic [lom_pkg::WAIT_W-1:0]  wait_ff, wait_in;
   lom_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // cancel flag memory
   logic                        cxl_mem [lom_pkg::MAX_MESSAGES];
   logic                        cxl_rd_ff;
   logic                        mem_we, mem_wdata;
   logic [lom_pkg::ID_W-1:0]    mem_waddr;

   lom_pkg::cmd_type            bid_cmd, ask_cmd;
   lom_pkg::entry_type          bid_head, ask_head, opp_head;
   logic                        bid_full, ask_full;
   logic [lom_pkg::SUM_W-1:0]   bid_sum, ask_sum;

   logic                        rsp_free, is_buy, crosses;
   logic [lom_pkg::SIZE_W-1:0]  fill;
   logic [lom_pkg::PRICE_W-1:0] price_sat;

   lom_book #(.DEPTH(BOOK_DEPTH), .IS_BID(1'b1)) u_bid (
      .clock      (clock),
      .reset      (reset),
      .cmd        (bid_cmd),
      .head_ent   (bid_head),
      .full       (bid_full),
      .head_total (bid_sum)
   );

   lom_book #(.DEPTH(BOOK_DEPTH), .IS_BID(1'b0)) u_ask (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ask_cmd),
      .head_ent   (ask_head),
      .full       (ask_full),
      .head_total (ask_sum)
   );

   // match terms against the opposite book head
   assign is_buy    = (mode_ff == lom_pkg::MODE_BUY);
   assign opp_head  = is_buy ? ask_head : bid_head;
   assign crosses   = opp_head.valid &&
                      (is_buy ? (opp_head.limit <= limit_ff) : (opp_head.limit >= limit_ff));
   assign fill      = (opp_head.rem < size_ff) ? opp_head.rem : size_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign price_sat = (req_chan.price > lom_pkg::PRICE_TOP) ? lom_pkg::PRICE_TOP
                                                            : req_chan.price;

   assign req_chan.ready = (state_ff == lom_pkg::ST_IDLE);

   // result port
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = rsp_ff.kind;
   assign rsp_chan.trade_size  = rsp_ff.trade_size;
   assign rsp_chan.trade_price = rsp_ff.trade_price;
   assign rsp_chan.bid_total   = rsp_ff.bid_total;
   assign rsp_chan.bid_level   = rsp_ff.bid_level;
   assign rsp_chan.ask_total   = rsp_ff.ask_total;
   assign rsp_chan.ask_level   = rsp_ff.ask_level;
   assign rsp_chan.overflow    = rsp_ff.overflow;
   assign rsp_chan.last        = rsp_ff.last;

   // sequencer: next state, book commands, result loads
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      size_in      = size_ff;
      limit_in     = limit_ff;
      target_in    = target_ff;
      id_in        = id_ff;
      ovf_in       = ovf_ff;
      wait_in      = wait_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = 1'b0;
      bid_cmd      = '0;
      ask_cmd      = '0;

      unique case (state_ff)
         lom_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == lom_pkg::ID_LAST) state_in = lom_pkg::ST_IDLE;
         end
         lom_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               mode_in   = req_chan.mode;
               size_in   = req_chan.order_size;
               limit_in  = price_sat;
               target_in = req_chan.target_order;
               id_in     = cnt_ff;
               cnt_in    = cnt_ff + 1'b1;
               ovf_in    = 1'b0;
               state_in  = lom_pkg::ST_WITHDRAW;
            end
         end
         lom_pkg::ST_WITHDRAW: begin
            // number reuse: pull any order still resting under this number
            bid_cmd.op = lom_pkg::BOOK_REMOVE;
            bid_cmd.id = id_ff;
            ask_cmd.op = lom_pkg::BOOK_REMOVE;
            ask_cmd.id = id_ff;
            mem_we     = 1'b1;
            mem_waddr  = id_ff;
            mem_wdata  = 1'b0;
            wait_in    = '0;
            if (mode_ff == lom_pkg::MODE_BUY || mode_ff == lom_pkg::MODE_SELL) begin
               state_in = lom_pkg::ST_MATCH;
            end else if (mode_ff == lom_pkg::MODE_CANCEL) begin
               state_in = lom_pkg::ST_CXL_READ;
            end else begin
               state_in = lom_pkg::ST_QUOTE;
            end
         end
         lom_pkg::ST_MATCH: begin
            if (size_ff != '0 && crosses) begin
               if (rsp_free) begin
                  rsp_in             = '0;
                  rsp_in.kind        = lom_pkg::KIND_TRADE;
                  rsp_in.trade_size  = fill;
                  rsp_in.trade_price = opp_head.limit;
                  rsp_valid_in       = 1'b1;
                  size_in            = size_ff - fill;
                  if (is_buy) begin
                     ask_cmd.op   = (opp_head.rem == fill) ? lom_pkg::BOOK_POP
                                                           : lom_pkg::BOOK_FILL;
                     ask_cmd.fill = fill;
                  end else begin
                     bid_cmd.op   = (opp_head.rem == fill) ? lom_pkg::BOOK_POP
                                                           : lom_pkg::BOOK_FILL;
                     bid_cmd.fill = fill;
                  end
               end
            end else if (size_ff != '0) begin
               state_in = lom_pkg::ST_REST;
            end else begin
               state_in = lom_pkg::ST_QUOTE;
            end
         end
         lom_pkg::ST_REST: begin
            // remainder rests unless its side is full
            if (is_buy) begin
               bid_cmd.op        = lom_pkg::BOOK_INSERT;
               bid_cmd.ent.valid = 1'b1;
               bid_cmd.ent.id    = id_ff;
               bid_cmd.ent.limit = limit_ff;
               bid_cmd.ent.rem   = size_ff;
               if (bid_full) begin
                  bid_cmd.op = lom_pkg::BOOK_HOLD;
                  ovf_in     = 1'b1;
               end
            end else begin
               ask_cmd.op        = lom_pkg::BOOK_INSERT;
               ask_cmd.ent.valid = 1'b1;
               ask_cmd.ent.id    = id_ff;
               ask_cmd.ent.limit = limit_ff;
               ask_cmd.ent.rem   = size_ff;
               if (ask_full) begin
                  ask_cmd.op = lom_pkg::BOOK_HOLD;
                  ovf_in     = 1'b1;
               end
            end
            state_in = lom_pkg::ST_QUOTE;
         end
         lom_pkg::ST_CXL_READ: begin
            state_in = lom_pkg::ST_CXL_CHECK;
         end
         lom_pkg::ST_CXL_CHECK: begin
            if (!cxl_rd_ff) begin
               mem_we     = 1'b1;
               mem_waddr  = target_ff;
               mem_wdata  = 1'b1;
               bid_cmd.op = lom_pkg::BOOK_REMOVE;
               bid_cmd.id = target_ff;
               ask_cmd.op = lom_pkg::BOOK_REMOVE;
               ask_cmd.id = target_ff;
            end
            state_in = lom_pkg::ST_QUOTE;
         end
         lom_pkg::ST_QUOTE: begin
            // wait for the adder trees to settle on the final books
            if (wait_ff != lom_pkg::WAIT_W'(lom_pkg::TREE_LEVELS)) begin
               wait_in = wait_ff + 1'b1;
            end else if (rsp_free) begin
               rsp_in           = '0;
               rsp_in.kind      = lom_pkg::KIND_QUOTE;
               rsp_in.bid_total = bid_sum;
               rsp_in.bid_level = bid_head.valid ? bid_head.limit : '0;
               rsp_in.ask_total = ask_sum;
               rsp_in.ask_level = ask_head.valid ? ask_head.limit : lom_pkg::PRICE_TOP;
               rsp_in.overflow  = ovf_ff;
               rsp_in.last      = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = lom_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lom_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lom_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      size_ff   <= size_in;
      limit_ff  <= limit_in;
      target_ff <= target_in;
      id_ff     <= id_in;
      ovf_ff    <= ovf_in;
      rsp_ff    <= rsp_in;
   end

   // cancel flags: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) cxl_mem[mem_waddr] <= mem_wdata;
      cxl_rd_ff <= cxl_mem[target_ff];
   end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the limit order matcher
// Drives directed and random buy, sell, cancel and unused-mode messages in random
// bursts, predicts trades and quotes with a behavioral order book and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH = 63;
   localparam int CYCLE_LIMIT = 1000000;

   // resting side of a message number
   localparam logic [1:0] SIDE_NONE = 2'd0;
   localparam logic [1:0] SIDE_BID  = 2'd1;
   localparam logic [1:0] SIDE_ASK  = 2'd2;

   typedef struct packed {
      logic [1:0]                  mode;
      logic [lom_pkg::SIZE_W-1:0]  order_size;
      logic [lom_pkg::PRICE_W-1:0] price;
      logic [lom_pkg::ID_W-1:0]    target_order;
   } msg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lom_req_if req_chan ();
   lom_rsp_if rsp_chan ();

   limit_order_matcher_unit #(.BOOK_DEPTH(DEPTH)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // order book model
   logic [lom_pkg::ID_W-1:0]    next_id;
   logic [1:0]                  side_of [lom_pkg::MAX_MESSAGES];
   logic                        cxl_of [lom_pkg::MAX_MESSAGES];
   logic [lom_pkg::SIZE_W-1:0]  rem_of [lom_pkg::MAX_MESSAGES];
   logic [lom_pkg::PRICE_W-1:0] lim_of [lom_pkg::MAX_MESSAGES];
   int                          bids [$];
   int                          asks [$];
   logic [lom_pkg::SUM_W-1:0]   bid_sum [lom_pkg::PRICE_LEVELS];
   logic [lom_pkg::SUM_W-1:0]   ask_sum [lom_pkg::PRICE_LEVELS];

   msg_type          pending_msgs [$];
   lom_pkg::rsp_type expected_rsps [$];
   int               mismatches = 0;
   int               cycles = 0;
   bit               stim_done = 0;

   function automatic void drop_from(ref int book [$], input int id);
      foreach (book[i]) if (book[i] == id) begin
         book.delete(i);
         return;
      end
   endfunction

   function automatic void withdraw_order(int id);
      if (side_of[id] == SIDE_BID) begin
         drop_from(bids, id);
         bid_sum[lim_of[id]] -= lom_pkg::SUM_W'(rem_of[id]);
      end else if (side_of[id] == SIDE_ASK) begin
         drop_from(asks, id);
         ask_sum[lim_of[id]] -= lom_pkg::SUM_W'(rem_of[id]);
      end
      side_of[id] = SIDE_NONE;
   endfunction

   // compute the trade beats and closing quote for one message
   function automatic void predict_msg(msg_type m);
      int id, r, pos;
      logic [lom_pkg::SIZE_W-1:0] left, fill;
      logic [lom_pkg::PRICE_W-1:0] lp, bp, ap;
      bit is_buy, ovf;
      lom_pkg::rsp_type t;
      id = next_id;
      next_id = next_id + 1'b1;
      ovf = 0;
      left = m.order_size;
      withdraw_order(id);
      cxl_of[id] = 1'b0;
      if (m.mode == lom_pkg::MODE_BUY || m.mode == lom_pkg::MODE_SELL) begin
         is_buy = (m.mode == lom_pkg::MODE_BUY);
         forever begin
            if (left == 0) break;
            if (is_buy ? asks.size() == 0 : bids.size() == 0) break;
            r = is_buy ? asks[0] : bids[0];
            lp = lim_of[r];
            if (is_buy ? (lp > m.price) : (lp < m.price)) break;
            fill = (rem_of[r] < left) ? rem_of[r] : left;
            left -= fill;
            rem_of[r] -= fill;
            if (is_buy) ask_sum[lp] -= lom_pkg::SUM_W'(fill);
            else        bid_sum[lp] -= lom_pkg::SUM_W'(fill);
            if (rem_of[r] == 0) begin
               if (is_buy) void'(asks.pop_front());
               else        void'(bids.pop_front());
               side_of[r] = SIDE_NONE;
            end
            t = '0;
            t.kind = lom_pkg::KIND_TRADE;
            t.trade_size = fill;
            t.trade_price = lp;
            expected_rsps.push_back(t);
         end
         if (left > 0) begin
            if ((is_buy ? bids.size() : asks.size()) >= DEPTH) ovf = 1;
            else begin
               rem_of[id] = left;
               lim_of[id] = m.price;
               if (is_buy) begin
                  pos = bids.size();
                  foreach (bids[i]) if (m.price > lim_of[bids[i]]) begin
                     pos = i;
                     break;
                  end
                  bids.insert(pos, id);
                  side_of[id] = SIDE_BID;
                  bid_sum[m.price] += lom_pkg::SUM_W'(left);
               end else begin
                  pos = asks.size();
                  foreach (asks[i]) if (m.price < lim_of[asks[i]]) begin
                     pos = i;
                     break;
                  end
                  asks.insert(pos, id);
                  side_of[id] = SIDE_ASK;
                  ask_sum[m.price] += lom_pkg::SUM_W'(left);
               end
            end
         end
      end else if (m.mode == lom_pkg::MODE_CANCEL) begin
         if (!cxl_of[m.target_order]) begin
            cxl_of[m.target_order] = 1'b1;
            withdraw_order(m.target_order);
         end
      end
      bp = bids.size() > 0 ? lim_of[bids[0]] : '0;
      ap = asks.size() > 0 ? lim_of[asks[0]] : lom_pkg::PRICE_TOP;
      t = '0;
      t.kind = lom_pkg::KIND_QUOTE;
      t.bid_total = bid_sum[bp];
      t.bid_level = bp;
      t.ask_total = ask_sum[ap];
      t.ask_level = ap;
      t.overflow = ovf;
      t.last = 1'b1;
      expected_rsps.push_back(t);
   endfunction

   function automatic msg_type make_msg(logic [1:0] md, int sz, int pr, int tg);
      msg_type m;
      m.mode = md;
      m.order_size = lom_pkg::SIZE_W'(sz);
      m.price = lom_pkg::PRICE_W'(pr);
      m.target_order = lom_pkg::ID_W'(tg);
      return m;
   endfunction

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // stimulus
   initial begin
      int sent, k, md;
      for (int i = 0; i < lom_pkg::MAX_MESSAGES; i++) begin
         side_of[i] = SIDE_NONE; cxl_of[i] = 0; rem_of[i] = 0; lim_of[i] = 0;
      end
      for (int i = 0; i < lom_pkg::PRICE_LEVELS; i++) begin
         bid_sum[i] = 0; ask_sum[i] = 0;
      end
      next_id = 0;
      // directed: extremes, a sweep, cancels, a full book, unused mode, size 0
      pending_msgs.push_back(make_msg(lom_pkg::MODE_SELL, 65535, 1023, 0));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_BUY, 65535, 0, 0));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_SELL, 100, 500, 0));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_SELL, 50, 500, 0));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_SELL, 30, 400, 0));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_BUY, 170, 600, 0));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_CANCEL, 0, 0, 1));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_CANCEL, 0, 0, 1));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_CANCEL, 0, 0, 1023));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_CANCEL, 0, 0, 6));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_NOP, 65535, 1023, 1023));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_BUY, 0, 300, 0));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_BUY, 1, 1, 0));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_SELL, 65535, 1, 0));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_SELL, 1, 1022, 0));
      // fill the bid side beyond its depth, then sweep it
      for (int i = 0; i < DEPTH + 3; i++)
         pending_msgs.push_back(make_msg(lom_pkg::MODE_BUY, 1000 + i, 10 + (i % 7), 0));
      pending_msgs.push_back(make_msg(lom_pkg::MODE_SELL, 65535, 0, 0));
      sent = 0;
      while (sent < 228) begin
         k = $urandom_range(99);
         md = (k < 42) ? lom_pkg::MODE_BUY : (k < 84) ? lom_pkg::MODE_SELL :
              (k < 97) ? lom_pkg::MODE_CANCEL : lom_pkg::MODE_NOP;
         pending_msgs.push_back(make_msg(md[1:0],
            ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1, 400),
            ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(490, 510),
            ($urandom_range(4) == 0) ? $urandom_range(1023)
                                     : (int'(next_id) + sent + 90 - $urandom_range(20)) % 1024));
         sent++;
      end
      while (pending_msgs.size() > 0 || req_chan.valid) @(posedge clock);
      stim_done = 1;
   end

   // reset
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   initial begin
      req_chan.valid = 0;
      req_chan.mode = 0;
      req_chan.order_size = 0;
      req_chan.price = 0;
      req_chan.target_order = 0;
      rsp_chan.ready = 0;
   end

   always @(posedge clock) begin
      msg_type m;
      if (!reset) begin
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_msgs.size() > 0) begin
               m = pending_msgs.pop_front();
               predict_msg(m);
               req_chan.valid <= 1'b1;
               req_chan.mode <= m.mode;
               req_chan.order_size <= m.order_size;
               req_chan.price <= m.price;
               req_chan.target_order <= m.target_order;
               if (burst_left > 0) burst_left <= burst_left - 1;
               else begin
                  burst_left <= $urandom_range(12);
                  gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(30);
               end
            end else req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern: fixed period, duty changed now and then
   int stall_phase = 0;
   int stall_len = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_len <= $urandom_range(3) == 0 ? 0 : $urandom_range(6);
      rsp_chan.ready <= (stall_phase % 8) >= stall_len;
   end

   // monitor and checker
   always @(posedge clock) begin
      lom_pkg::rsp_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.kind, rsp_chan.trade_size, rsp_chan.trade_price,
                rsp_chan.bid_total, rsp_chan.bid_level, rsp_chan.ask_total,
                rsp_chan.ask_level, rsp_chan.overflow, rsp_chan.last};
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // end of run and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
